// ===== design/dtar_pkg.sv =====
// Shared types and codes for the delayed threshold alarm relay block.
`timescale 1ns / 1ps

package dtar_pkg;

    localparam int CNT_W  = 16;
    localparam int MODE_W = 5;
    localparam int VAL_W  = 16;

    // Command codes carried in the low bits of the input tuser.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_OPEN  = 2'd2;

    // Work modes; every mode below MODE_REMOTE clears the channel on a tick.
    localparam logic [MODE_W-1:0] MODE_REMOTE    = 5'd9;
    localparam logic [MODE_W-1:0] MODE_LT_SEL    = 5'd10;
    localparam logic [MODE_W-1:0] MODE_GT_SEL    = 5'd11;
    localparam logic [MODE_W-1:0] MODE_LATCH_LT  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_LATCH_GT  = 5'd13;
    localparam logic [MODE_W-1:0] MODE_LT_PHASE  = 5'd14;
    localparam logic [MODE_W-1:0] MODE_GT_PHASE  = 5'd15;
    localparam logic [MODE_W-1:0] MODE_LT_LINE   = 5'd16;
    localparam logic [MODE_W-1:0] MODE_GT_LINE   = 5'd17;
    localparam logic [MODE_W-1:0] MODE_FORCE_OFF = 5'd18;
    localparam logic [MODE_W-1:0] MODE_FORCE_ON  = 5'd19;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;
    localparam logic [1:0] REG_DRIVE = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] on_cnt;
        logic [CNT_W-1:0] off_cnt;
        logic             relay;
        logic             alarm;
    } t_chan_state;

    // Declared high to low so the packed layout matches the input tdata.
    typedef struct packed {
        logic [VAL_W-1:0] line_ca;
        logic [VAL_W-1:0] line_bc;
        logic [VAL_W-1:0] line_ab;
        logic [VAL_W-1:0] phase_c;
        logic [VAL_W-1:0] phase_b;
        logic [VAL_W-1:0] phase_a;
        logic [VAL_W-1:0] sel;
    } t_meas;

endpackage

// ===== design/dtar_eval.sv =====
// Next-state logic of one alarm channel for one command.
`timescale 1ns / 1ps

module dtar_eval
    import dtar_pkg::*;
(
    input  logic [1:0]        i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CNT_W-1:0]  i_limit,
    input  logic [CNT_W-1:0]  i_delay,
    input  t_meas             i_meas,
    input  t_chan_state       i_cur,
    output t_chan_state       o_nxt
);

    logic             w_lt_sel;
    logic             w_gt_sel;
    logic             w_lt_phase;
    logic             w_gt_phase;
    logic             w_lt_line;
    logic             w_gt_line;
    logic             w_cond;
    logic [CNT_W-1:0] w_on_inc;
    logic [CNT_W-1:0] w_off_inc;

    assign w_lt_sel   = i_meas.sel < i_limit;
    assign w_gt_sel   = i_meas.sel > i_limit;
    assign w_lt_phase = (i_meas.phase_a < i_limit) || (i_meas.phase_b < i_limit) ||
                        (i_meas.phase_c < i_limit);
    assign w_gt_phase = (i_meas.phase_a > i_limit) || (i_meas.phase_b > i_limit) ||
                        (i_meas.phase_c > i_limit);
    assign w_lt_line  = (i_meas.line_ab < i_limit) || (i_meas.line_bc < i_limit) ||
                        (i_meas.line_ca < i_limit);
    assign w_gt_line  = (i_meas.line_ab > i_limit) || (i_meas.line_bc > i_limit) ||
                        (i_meas.line_ca > i_limit);

    // Counters wrap at 16 bits.
    assign w_on_inc  = i_cur.on_cnt + CNT_W'(1);
    assign w_off_inc = i_cur.off_cnt + CNT_W'(1);

    always_comb begin
        case (i_mode)
            MODE_LT_SEL, MODE_LATCH_LT: w_cond = w_lt_sel;
            MODE_GT_SEL, MODE_LATCH_GT: w_cond = w_gt_sel;
            MODE_LT_PHASE:              w_cond = w_lt_phase;
            MODE_GT_PHASE:              w_cond = w_gt_phase;
            MODE_LT_LINE:               w_cond = w_lt_line;
            MODE_GT_LINE:               w_cond = w_gt_line;
            default:                    w_cond = 1'b0;
        endcase
    end

    always_comb begin
        o_nxt = i_cur;
        case (i_cmd)
            CMD_TICK: begin
                if (i_mode < MODE_REMOTE) begin
                    o_nxt = '0;
                end else begin
                    case (i_mode)
                        MODE_LT_SEL, MODE_GT_SEL, MODE_LT_PHASE, MODE_GT_PHASE,
                        MODE_LT_LINE, MODE_GT_LINE: begin
                            if (w_cond) begin
                                o_nxt.off_cnt = '0;
                                o_nxt.on_cnt  = w_on_inc;
                                if (w_on_inc > i_delay) begin
                                    o_nxt.relay  = 1'b1;
                                    o_nxt.alarm  = 1'b1;
                                    o_nxt.on_cnt = '0;
                                end
                            end else begin
                                o_nxt.on_cnt  = '0;
                                o_nxt.off_cnt = w_off_inc;
                                if (w_off_inc > i_delay) begin
                                    o_nxt = '0;
                                end
                            end
                        end
                        MODE_LATCH_LT, MODE_LATCH_GT: begin
                            // Latching: only the on-counter runs, nothing releases.
                            if (w_cond) begin
                                o_nxt.on_cnt = w_on_inc;
                                if (w_on_inc > i_delay) begin
                                    o_nxt.relay  = 1'b1;
                                    o_nxt.alarm  = 1'b1;
                                    o_nxt.on_cnt = '0;
                                end
                            end else begin
                                o_nxt.on_cnt = '0;
                            end
                        end
                        MODE_FORCE_OFF: begin
                            o_nxt.relay = 1'b0;
                            o_nxt.alarm = 1'b0;
                        end
                        MODE_FORCE_ON: begin
                            o_nxt.relay = 1'b1;
                            o_nxt.alarm = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_CLOSE: begin
                if (i_mode == MODE_REMOTE) begin
                    o_nxt.relay = 1'b1;
                end
            end
            CMD_OPEN: begin
                if (i_mode == MODE_REMOTE) begin
                    o_nxt.relay = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/delayed_threshold_alarm_relays.sv =====
// Top level: four delayed threshold alarm relay channels on a stream interface.
`timescale 1ns / 1ps

// Each input item addresses one channel with a tick, remote close or remote open
// command and returns exactly one status item for that channel. The block takes
// one item per clock as long as the result side keeps taking: an item sits in
// the input register while the channel's state is read, updated and the status
// is written to the output register, from which the result is taken. Channel
// state (two 16-bit wrapping counters, relay and alarm bits) lives in flip-flops
// and is updated by the item before it, so back-to-back items on the same channel
// see each other's effect. Configuration writes are to be made only while no item
// is in flight; a mode write that changes a channel's mode clears that channel.
// Channels at or beyond NUM_CHANNELS report relay, alarm and pin as 0.
module delayed_threshold_alarm_relays
    import dtar_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sel, phase_a, phase_b, phase_c, line_ab, line_bc, line_ca (16 bits each)
    input  logic [111:0] s_axis_tdata,
    // command [1:0], channel [3:2]
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // relay_on [0], alarm_active [1], pin_driven [2], relay_word [6:3], zero [7]
    output logic [7:0]   m_axis_tdata,
    // out_channel [1:0]
    output logic [1:0]   m_axis_tuser
);

    // Configuration registers.
    logic [4*MODE_W-1:0] r_mode;
    logic [63:0]         r_limit;
    logic [63:0]         r_delay;
    logic [1:0]          r_drive;

    // Input register.
    logic                r_s1_valid;
    t_meas               r_s1_meas;
    logic [1:0]          r_s1_cmd;
    logic [1:0]          r_s1_ch;

    // Output register.
    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic [1:0]          r_out_ch;

    t_chan_state         r_state [NUM_CHANNELS];

    logic                w_adv;
    logic                w_ch_ok;
    logic [MODE_W-1:0]   w_mode;
    logic [CNT_W-1:0]    w_limit;
    logic [CNT_W-1:0]    w_delay;
    t_chan_state         w_cur;
    t_chan_state         w_nxt;
    logic [3:0]          w_word;
    logic                w_pin;
    logic [7:0]          n_out_data;
    logic                n_out_valid;

    assign w_adv         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_ch_ok       = int'(r_s1_ch) < NUM_CHANNELS;

    // Pick the addressed channel's settings and state.
    always_comb begin
        w_mode  = '0;
        w_limit = '0;
        w_delay = '0;
        w_cur   = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (r_s1_ch == 2'(c)) begin
                w_mode  = r_mode[MODE_W*c +: MODE_W];
                w_limit = r_limit[CNT_W*c +: CNT_W];
                w_delay = r_delay[CNT_W*c +: CNT_W];
                w_cur   = r_state[c];
            end
        end
    end

    dtar_eval u_eval (
        .i_cmd   (r_s1_cmd),
        .i_mode  (w_mode),
        .i_limit (w_limit),
        .i_delay (w_delay),
        .i_meas  (r_s1_meas),
        .i_cur   (w_cur),
        .o_nxt   (w_nxt)
    );

    // Relay word after this item: the addressed channel takes its new value.
    always_comb begin
        w_word = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (w_ch_ok && (r_s1_ch == 2'(c))) begin
                w_word[c] = w_nxt.relay;
            end else begin
                w_word[c] = r_state[c].relay;
            end
        end
    end

    assign w_pin = r_s1_ch[1] ? r_drive[1] : r_drive[0];

    always_comb begin
        n_out_data = {1'b0, w_word, 3'b000};
        if (w_ch_ok) begin
            n_out_data[2:0] = {w_pin, w_nxt.alarm, w_nxt.relay};
        end
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_limit <= '0;
            r_delay <= '0;
            r_drive <= 2'b11;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_data[4*MODE_W-1:0];
                REG_LIMIT: r_limit <= i_cfg_data;
                REG_DELAY: r_delay <= i_cfg_data;
                REG_DRIVE: r_drive <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Channel state: clear on a mode change, else take the evaluated item.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (!i_rst_n) begin
                r_state[c] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == REG_MODE) &&
                         (i_cfg_data[MODE_W*c +: MODE_W] != r_mode[MODE_W*c +: MODE_W])) begin
                r_state[c] <= '0;
            end else if (w_adv && w_ch_ok && (r_s1_ch == 2'(c))) begin
                r_state[c] <= w_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: load the input item on acceptance, the result on advance.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_meas <= t_meas'(s_axis_tdata);
            r_s1_cmd  <= s_axis_tuser[1:0];
            r_s1_ch   <= s_axis_tuser[3:2];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
            r_out_ch   <= r_s1_ch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ch;

    // A held input item is not lost and keeps its channel and command while the result side stalls.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !m_axis_tready |=>
            r_s1_valid && $stable(r_s1_ch) && $stable(r_s1_cmd))
        else $error("input item dropped during output stall");

    // Every advance presents a result on the next cycle.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> m_axis_tvalid)
        else $error("advanced item produced no result");

    // On- and off-counters of a channel are never running together.
    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (w_cur.on_cnt == '0) || (w_cur.off_cnt == '0))
        else $error("on and off counters both nonzero");

    // The reported relay state agrees with its bit in the relay word.
    a_relay_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (int'(m_axis_tuser) < NUM_CHANNELS) |->
            m_axis_tdata[0] == m_axis_tdata[3 + m_axis_tuser])
        else $error("relay_on disagrees with relay_word");

endmodule
